@@ hdl/segsph_pkg.sv @@
// segsph_pkg: shared constants for the segment / sphere crossing unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package segsph_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 28;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_PTR_W     = 2;

endpackage

@@ hdl/segment_sphere_intersection_unit.sv @@
// segment_sphere_intersection_unit: top level of the crossing fraction block
// depends on segsph_pkg, segsph_front, segsph_fifo, segsph_back
//
//   channel  | dir | fields
//   ---------+-----+-------------------------------------------------------
//   s_axis   | in  | centre xyz, inner xyz, outer xyz, sphere_radius
//   m_axis   | out | crossing_fraction, unsigned Q1.FRAC_BITS
//
// one transfer per cycle sustained while m_axis_tready_i stays high; every stage is a pipeline step
// path: the front stages, the queue, then in the back a capture stage,
//   2*COORD_WIDTH+3 square root steps, root select, FRAC_BITS divider steps, output register
// the square root chain, one result bit per stage, sets the depth
// front and back stall on their own; the 4-entry queue parts them
// reset (rst_ni low) clears all valid flags; payload is not reset
`timescale 1ns / 1ps

module segment_sphere_intersection_unit #(
  parameter int unsigned COORD_WIDTH = segsph_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = segsph_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // centre_x, centre_y, centre_z, inner_x, inner_y, inner_z,
  // outer_x, outer_y, outer_z, sphere_radius, zero fill
  input  logic [((10*COORD_WIDTH-1+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // crossing_fraction, zero fill
  output logic [((FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata_o
);
  import segsph_pkg::*;

  localparam int unsigned MW  = 2 * COORD_WIDTH + 2;
  localparam int unsigned SW  = 2 * COORD_WIDTH + 4;
  localparam int unsigned DSW = 4 * COORD_WIDTH + 6;
  localparam int unsigned QW  = MW + SW + DSW + 1;
  localparam int unsigned OW  = ((FRAC_BITS+1+7)/8)*8;

  logic            f_valid, f_ready;
  logic [MW-1:0]   f_a;
  logic [SW-1:0]   f_h;
  logic [DSW-1:0]  f_disc;
  logic            f_ok;

  logic            q_valid, q_ready;
  logic [QW-1:0]   q_data;

  logic [FRAC_BITS:0] frac;

  // front: differences, dot products and discriminant
  segsph_front #(
    .CW (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i[10*COORD_WIDTH-2:0]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_a_o     (f_a),
    .out_h_o     (f_h),
    .out_disc_o  (f_disc),
    .out_ok_o    (f_ok)
  );

  // decoupling queue
  segsph_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_ok, f_disc, f_h, f_a}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // back: square root, root choice, fraction
  segsph_back #(
    .CW (COORD_WIDTH),
    .FB (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_a_i      (q_data[MW-1:0]),
    .in_h_i      (q_data[MW +: SW]),
    .in_disc_i   (q_data[MW+SW +: DSW]),
    .in_ok_i     (q_data[QW-1]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_frac_o  (frac)
  );

  assign m_axis_tdata_o = OW'(frac);

endmodule

@@ hdl/segsph_front.sv @@
// segsph_front: pipelined front end, forms a, h and the discriminant
// depends on segsph_pkg
`timescale 1ns / 1ps

module segsph_front #(
  parameter int unsigned CW = segsph_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [10*CW-2:0]    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2*CW+1:0]     out_a_o,
  output logic [2*CW+3:0]     out_h_o,
  output logic [4*CW+5:0]     out_disc_o,
  output logic                out_ok_o
);
  import segsph_pkg::*;

  localparam int unsigned DW  = CW + 1;
  localparam int unsigned SW  = 2 * CW + 4;
  localparam int unsigned MW  = 2 * CW + 2;
  localparam int unsigned HW  = CW + 1;
  localparam int unsigned PW  = 4 * HW;
  localparam int unsigned DSW = 4 * CW + 6;
  localparam int unsigned NST = 8;

  logic [NST-1:0] v_q;
  logic           en;

  logic signed [DW-1:0]   d_q [3];
  logic signed [DW-1:0]   p_q [3];
  logic [CW-2:0]          rad_q;
  logic signed [2*DW-1:0] dd_q [3];
  logic signed [2*DW-1:0] dp_q [3];
  logic signed [2*DW-1:0] pp_q [3];
  logic [2*CW-3:0]        rr_q;
  logic signed [SW-1:0]   a3_q, h3_q, c3_q;
  logic signed [SW-1:0]   hneg, cneg_v;
  logic [MW-1:0]          am4_q, hm4_q, cm4_q;
  logic signed [SW-1:0]   h4_q;
  logic                   cn4_q;
  logic [2*HW-1:0]        hh00_q, hh01_q, hh11_q, ac00_q, ac01_q, ac10_q, ac11_q;
  logic [MW-1:0]          a5_q;
  logic signed [SW-1:0]   h5_q;
  logic                   cn5_q;
  logic [PW-1:0]          hhp_q, acp_q;
  logic [2*HW:0]          hhx_q, acx_q;
  logic [MW-1:0]          a6_q;
  logic signed [SW-1:0]   h6_q;
  logic                   cn6_q;
  logic [PW-1:0]          hhf_q, acf_q;
  logic [MW-1:0]          a7_q;
  logic signed [SW-1:0]   h7_q;
  logic                   cn7_q;
  logic [MW-1:0]          a8_q;
  logic signed [SW-1:0]   h8_q;
  logic [DSW-1:0]         disc8_q;
  logic                   ok8_q;

  // whole pipe holds when the last stage cannot hand off
  assign en         = !(v_q[NST-1] && !out_ready_i);
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  assign hneg   = -h3_q;
  assign cneg_v = -c3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // differences: d = outer - inner, p = inner - centre
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= $signed({in_data_i[(6+k)*CW+CW-1], in_data_i[(6+k)*CW +: CW]})
                - $signed({in_data_i[(3+k)*CW+CW-1], in_data_i[(3+k)*CW +: CW]});
        p_q[k] <= $signed({in_data_i[(3+k)*CW+CW-1], in_data_i[(3+k)*CW +: CW]})
                - $signed({in_data_i[k*CW+CW-1], in_data_i[k*CW +: CW]});
      end
      rad_q <= in_data_i[9*CW +: CW-1];
      // products
      for (int k = 0; k < 3; k++) begin
        dd_q[k] <= d_q[k] * d_q[k];
        dp_q[k] <= d_q[k] * p_q[k];
        pp_q[k] <= p_q[k] * p_q[k];
      end
      rr_q <= rad_q * rad_q;
      // dot products
      a3_q <= SW'(dd_q[0]) + SW'(dd_q[1]) + SW'(dd_q[2]);
      h3_q <= SW'(dp_q[0]) + SW'(dp_q[1]) + SW'(dp_q[2]);
      c3_q <= SW'(pp_q[0]) + SW'(pp_q[1]) + SW'(pp_q[2]) - $signed(SW'(rr_q));
      // magnitudes for the wide products
      am4_q <= a3_q[MW-1:0];
      hm4_q <= h3_q[SW-1] ? hneg[MW-1:0] : h3_q[MW-1:0];
      cm4_q <= c3_q[SW-1] ? cneg_v[MW-1:0] : c3_q[MW-1:0];
      cn4_q <= c3_q[SW-1];
      h4_q  <= h3_q;
      // partial products of h*h and a*c
      hh00_q <= hm4_q[HW-1:0] * hm4_q[HW-1:0];
      hh01_q <= hm4_q[HW-1:0] * hm4_q[MW-1:HW];
      hh11_q <= hm4_q[MW-1:HW] * hm4_q[MW-1:HW];
      ac00_q <= am4_q[HW-1:0] * cm4_q[HW-1:0];
      ac01_q <= am4_q[HW-1:0] * cm4_q[MW-1:HW];
      ac10_q <= am4_q[MW-1:HW] * cm4_q[HW-1:0];
      ac11_q <= am4_q[MW-1:HW] * cm4_q[MW-1:HW];
      a5_q   <= am4_q;
      h5_q   <= h4_q;
      cn5_q  <= cn4_q;
      // cross terms
      hhp_q <= {hh11_q, hh00_q};
      acp_q <= {ac11_q, ac00_q};
      hhx_q <= {hh01_q, 1'b0};
      acx_q <= (2*HW+1)'(ac01_q) + (2*HW+1)'(ac10_q);
      a6_q  <= a5_q;
      h6_q  <= h5_q;
      cn6_q <= cn5_q;
      // full products
      hhf_q <= hhp_q + (PW'(hhx_q) << HW);
      acf_q <= acp_q + (PW'(acx_q) << HW);
      a7_q  <= a6_q;
      h7_q  <= h6_q;
      cn7_q <= cn6_q;
      // discriminant h*h - a*c
      disc8_q <= cn7_q ? (DSW'(hhf_q) + DSW'(acf_q)) : (DSW'(hhf_q) - DSW'(acf_q));
      ok8_q   <= (a7_q != '0) && !(cn7_q ? 1'b0 : (acf_q > hhf_q));
      a8_q    <= a7_q;
      h8_q    <= h7_q;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign out_a_o     = a8_q;
  assign out_h_o     = h8_q;
  assign out_disc_o  = disc8_q;
  assign out_ok_o    = ok8_q;

endmodule

@@ hdl/segsph_fifo.sv @@
// segsph_fifo: short queue between front and back end
// depends on segsph_pkg
`timescale 1ns / 1ps

module segsph_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import segsph_pkg::*;

  logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [QUEUE_PTR_W:0]   cnt_q;
  logic                   do_push, do_pop;

  assign push_ready_o = (cnt_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

@@ hdl/segsph_back.sv @@
// segsph_back: pipelined square root, root choice and fraction divider
// depends on segsph_pkg
`timescale 1ns / 1ps

module segsph_back #(
  parameter int unsigned CW = segsph_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FB = segsph_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2*CW+1:0]     in_a_i,
  input  logic [2*CW+3:0]     in_h_i,
  input  logic [4*CW+5:0]     in_disc_i,
  input  logic                in_ok_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FB:0]         out_frac_o
);
  import segsph_pkg::*;

  localparam int unsigned SW  = 2 * CW + 4;
  localparam int unsigned MW  = 2 * CW + 2;
  localparam int unsigned DSW = 4 * CW + 6;
  localparam int unsigned SQW = DSW / 2;
  localparam int unsigned RW  = SQW + 2;
  localparam int unsigned NW  = SW + 1;
  localparam int unsigned L   = SQW + FB + 4;

  logic [L-1:0] v_q;
  logic         en;

  // square root chain, index 0 is the capture stage
  logic [RW-1:0]         sr_w   [SQW+1];
  logic [SQW-1:0]        so_w   [SQW+1];
  logic [DSW-1:0]        sd_w   [SQW+1];
  logic [MW-1:0]         sa_w   [SQW+1];
  logic signed [SW-1:0]  sh_w   [SQW+1];
  logic                  sk_w   [SQW+1];

  logic [DSW-1:0]        d0_q;
  logic [MW-1:0]         a0_q;
  logic signed [SW-1:0]  h0_q;
  logic                  k0_q;

  logic signed [NW-1:0]  n1_q, n2_q;
  logic [MW-1:0]         ar1_q;
  logic                  kr1_q;

  // divider chain, index 0 is the root select stage
  logic [MW-1:0]         dr_w [FB+1];
  logic [MW-1:0]         da_w [FB+1];
  logic [FB-1:0]         dq_w [FB+1];
  logic                  df_w [FB+1];
  logic                  dh_w [FB+1];

  logic [MW-1:0]         nr2_q, ar2_q;
  logic                  full2_q, hit2_q;
  logic                  ok1, ok2;
  logic [FB:0]           frac_q;

  assign en         = !(v_q[L-1] && !out_ready_i);
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q <= in_disc_i;
      a0_q <= in_a_i;
      h0_q <= in_h_i;
      k0_q <= in_ok_i;
    end
  end

  assign sr_w[0] = '0;
  assign so_w[0] = '0;
  assign sd_w[0] = d0_q;
  assign sa_w[0] = a0_q;
  assign sh_w[0] = h0_q;
  assign sk_w[0] = k0_q;

  // one result bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    logic [RW-1:0]        rem_sh, trial;
    logic                 ge;
    logic [RW-1:0]        r_q;
    logic [SQW-1:0]       o_q;
    logic [DSW-1:0]       d_q;
    logic [MW-1:0]        a_q;
    logic signed [SW-1:0] h_q;
    logic                 k_q;

    assign rem_sh = {sr_w[k][RW-3:0], sd_w[k][DSW-1-2*k -: 2]};
    assign trial  = {so_w[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q <= ge ? (rem_sh - trial) : rem_sh;
        o_q <= {so_w[k][SQW-2:0], ge};
        d_q <= sd_w[k];
        a_q <= sa_w[k];
        h_q <= sh_w[k];
        k_q <= sk_w[k];
      end
    end

    assign sr_w[k+1] = r_q;
    assign so_w[k+1] = o_q;
    assign sd_w[k+1] = d_q;
    assign sa_w[k+1] = a_q;
    assign sh_w[k+1] = h_q;
    assign sk_w[k+1] = k_q;
  end

  // candidate numerators: s - h first, then -h - s
  assign ok1 = !n1_q[NW-1] && ($unsigned(n1_q) <= NW'(ar1_q));
  assign ok2 = !n2_q[NW-1] && ($unsigned(n2_q) <= NW'(ar1_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q  <= $signed(NW'(so_w[SQW])) - NW'(sh_w[SQW]);
      n2_q  <= -NW'(sh_w[SQW]) - $signed(NW'(so_w[SQW]));
      ar1_q <= sa_w[SQW];
      kr1_q <= sk_w[SQW];
      nr2_q   <= ok1 ? n1_q[MW-1:0] : n2_q[MW-1:0];
      full2_q <= ok1 ? (n1_q[MW-1:0] == ar1_q) : (n2_q[MW-1:0] == ar1_q);
      hit2_q  <= kr1_q && (ok1 || ok2);
      ar2_q   <= ar1_q;
    end
  end

  assign dr_w[0] = nr2_q;
  assign da_w[0] = ar2_q;
  assign dq_w[0] = '0;
  assign df_w[0] = full2_q;
  assign dh_w[0] = hit2_q;

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < FB; j++) begin : g_div
    logic [MW:0]   t;
    logic          ge;
    logic [MW:0]   t_sub;
    logic [MW-1:0] r_q, a_q;
    logic [FB-1:0] q_q;
    logic          f_q, h_q;

    assign t     = {dr_w[j], 1'b0};
    assign ge    = (t >= {1'b0, da_w[j]});
    assign t_sub = t - {1'b0, da_w[j]};

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q <= ge ? t_sub[MW-1:0] : t[MW-1:0];
        q_q <= {dq_w[j][FB-2:0], ge};
        a_q <= da_w[j];
        f_q <= df_w[j];
        h_q <= dh_w[j];
      end
    end

    assign dr_w[j+1] = r_q;
    assign da_w[j+1] = a_q;
    assign dq_w[j+1] = q_q;
    assign df_w[j+1] = f_q;
    assign dh_w[j+1] = h_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!dh_w[FB]) begin
        frac_q <= '0;
      end else if (df_w[FB]) begin
        frac_q <= {1'b1, {FB{1'b0}}};
      end else begin
        frac_q <= {1'b0, dq_w[FB]};
      end
    end
  end

  assign out_valid_o = v_q[L-1];
  assign out_frac_o  = frac_q;

endmodule

@@ hdl/segsph_checker.sv @@
// segsph_checker: port level assertions for the crossing fraction unit
// depends on segsph_pkg; bound to segment_sphere_intersection_unit
`timescale 1ns / 1ps

module segsph_checker #(
  parameter int unsigned FRAC_BITS = segsph_pkg::FRAC_BITS_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [((FRAC_BITS+1+7)/8)*8-1:0]     m_axis_tdata_o
);
  import segsph_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // fraction never exceeds one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[FRAC_BITS:0] <= ONE))
    else $error("fraction above one");

  // fill bits above the fraction stay zero
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o >> (FRAC_BITS+1)) == '0))
    else $error("nonzero fill bits");

endmodule

bind segment_sphere_intersection_unit segsph_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_segsph_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
